// File: design/assert_macros.svh
// Assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high
`define JFS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("jfs assertion failed");

// Check a property on every rising edge, reset included
`define JFS_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("jfs assertion failed");

`endif

// File: design/jfs_pkg.sv
`timescale 1ns / 1ps
package jfs_pkg;

  // Scan phases
  typedef enum logic [3:0] {
    PH_START0,
    PH_START1,
    PH_HUNT,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_HEADER,
    PH_DONE
  } phase_t;

  // Marker bytes
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] CODE_SOI  = 8'hD8;
  localparam logic [7:0] CODE_SOF0 = 8'hC0;
  localparam logic [7:0] CODE_SOF2 = 8'hC2;
  localparam logic [7:0] CODE_EOI  = 8'hD9;

  // Byte offsets inside a frame header, counted from the FF
  localparam logic [15:0] OFS_FIRST = 16'd2;
  localparam logic [15:0] OFS_H_HI  = 16'd5;
  localparam logic [15:0] OFS_H_LO  = 16'd6;
  localparam logic [15:0] OFS_W_HI  = 16'd7;
  localparam logic [15:0] OFS_W_LO  = 16'd8;
  localparam logic [15:0] OFS_LAST  = 16'd9;

  // Shortest segment length that leaves bytes to skip
  localparam logic [15:0] SEG_MIN_SKIP = 16'd3;
  localparam logic [15:0] SEG_LEN_BYTES = 16'd2;

  // One scan result
  typedef struct packed {
    logic        found;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } res_t;

endpackage

// File: design/jfs_in_if.sv
`timescale 1ns / 1ps
interface jfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// File: design/jfs_out_if.sv
`timescale 1ns / 1ps
interface jfs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] frame_width;
  logic [15:0] frame_height;

  modport source (output valid, output found, output frame_width, output frame_height,
                  input ready);
  modport sink (input valid, input found, input frame_width, input frame_height,
                output ready);
endinterface

// File: design/jfs_scan_core.sv
`timescale 1ns / 1ps
module jfs_scan_core
  import jfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  jfs_in_if.sink     bytes,
  input  logic       out_ready,
  output logic       res_load,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [15:0] count, count_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] held_height, held_height_next;
  logic [15:0] held_width, held_width_next;
  logic        found_flag, found_flag_next;
  logic        accept;
  logic [15:0] seg;
  logic [15:0] count_dec;
  logic [7:0]  b;

  assign bytes.ready = out_ready;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.data_byte;
  assign seg         = {length_high, b};
  assign count_dec   = (count != 16'd0) ? count - 16'd1 : 16'd0;

  // Next scan phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_START0: phase_next = (b == BYTE_FF) ? PH_START1 : PH_DONE;
      PH_START1: phase_next = (b == CODE_SOI) ? PH_HUNT : PH_DONE;
      PH_HUNT: begin
        if (b == BYTE_FF) phase_next = PH_MARKER;
      end
      PH_MARKER: begin
        if (b == CODE_SOF0 || b == CODE_SOF2) phase_next = PH_HEADER;
        else if (b == CODE_EOI)               phase_next = PH_DONE;
        else                                  phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: phase_next = PH_LEN_LO;
      PH_LEN_LO: phase_next = (seg >= SEG_MIN_SKIP) ? PH_SKIP : PH_HUNT;
      PH_SKIP: begin
        if (count_dec == 16'd0) phase_next = PH_HUNT;
      end
      PH_HEADER: begin
        if (count == OFS_LAST) phase_next = PH_DONE;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
    // Start over after the last byte of a file
    if (bytes.end_of_file) phase_next = PH_START0;
  end

  // Counter, length and captured frame size
  always_comb begin
    count_next       = count;
    length_high_next = length_high;
    held_height_next = held_height;
    held_width_next  = held_width;
    found_flag_next  = found_flag;
    case (phase)
      PH_MARKER: begin
        if (b == CODE_SOF0 || b == CODE_SOF2) count_next = OFS_FIRST;
      end
      PH_LEN_HI: length_high_next = b;
      PH_LEN_LO: begin
        if (seg >= SEG_MIN_SKIP) count_next = seg - SEG_LEN_BYTES;
      end
      PH_SKIP: count_next = count_dec;
      PH_HEADER: begin
        case (count)
          OFS_H_HI: held_height_next = {b, 8'h00};
          OFS_H_LO: held_height_next = {held_height[15:8], b};
          OFS_W_HI: held_width_next  = {b, 8'h00};
          OFS_W_LO: held_width_next  = {held_width[15:8], b};
          OFS_LAST: found_flag_next  = 1'b1;
          default:  ;
        endcase
        count_next = count + 16'd1;
      end
      default: ;
    endcase
  end

  // Result for the last byte of a file
  always_comb begin
    res_load = accept && bytes.end_of_file;
    if (found_flag_next) begin
      res.found        = 1'b1;
      res.frame_width  = held_width_next;
      res.frame_height = held_height_next;
    end else begin
      res.found        = 1'b0;
      res.frame_width  = 16'd0;
      res.frame_height = 16'd0;
    end
  end

  // Advance state on each accepted byte; clear it after the last one
  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.end_of_file)) begin
      phase       <= PH_START0;
      count       <= 16'd0;
      length_high <= 8'd0;
      held_height <= 16'd0;
      held_width  <= 16'd0;
      found_flag  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      count       <= count_next;
      length_high <= length_high_next;
      held_height <= held_height_next;
      held_width  <= held_width_next;
      found_flag  <= found_flag_next;
    end
  end

endmodule

// File: design/jfs_out_stage.sv
`timescale 1ns / 1ps
module jfs_out_stage
  import jfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       res_load,
  input  res_t       res,
  output logic       out_ready,
  jfs_out_if.source  results
);

  logic valid;
  res_t data;

  // Take a new result when empty or when the held one leaves this cycle
  assign out_ready = !valid || results.ready;

  assign results.valid        = valid;
  assign results.found        = data.found;
  assign results.frame_width  = data.frame_width;
  assign results.frame_height = data.frame_height;

  // Hold the result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (res_load) data <= res;
  end

endmodule

// File: design/jpeg_frame_size_scanner_top.sv
// JPEG frame size scanner: one file byte per transaction, one result per file.
// Throughput: one byte per cycle, set by the registered scan state update.
// Latency: the result is valid the cycle after the last byte is accepted.
// A held result stalls input only while the result port is not ready.
// Reset (synchronous, active high) returns to the start of a new file.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jpeg_frame_size_scanner_top
  import jfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  jfs_in_if.sink    bytes,
  jfs_out_if.source results
);

  logic res_load;
  res_t res;
  logic out_ready;

  // Scan state and result decode
  jfs_scan_core u_core (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .out_ready (out_ready),
    .res_load  (res_load),
    .res       (res)
  );

  // Result register
  jfs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_ready (out_ready),
    .results   (results)
  );

  // A not-found result carries zero size
  `JFS_ASSERT(a_zero_when_absent, clk, rst,
    results.valid && !results.found |-> results.frame_width == 16'd0 &&
    results.frame_height == 16'd0)
  // The last byte of a file yields a result on the next cycle
  `JFS_ASSERT(a_result_follows_eof, clk, rst,
    bytes.valid && bytes.ready && bytes.end_of_file |=> results.valid)
  // A stalled result blocks new bytes
  `JFS_ASSERT(a_stall_blocks_input, clk, rst,
    results.valid && !results.ready |-> !bytes.ready)

endmodule
